// ===== rtl/core/chc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chc_pkg
// Shared types and constants for the calibrated compass heading core.
// ----------------------------------------------------------------------------
package chc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FIELD_WIDTH      = 16;

    localparam logic [15:0] CAL_SAMPLES_RESET = 16'd200;

    // serial divider for 450*minor/major, quotient never exceeds 450 unless both components are zero
    localparam int          DIV_BITS  = 9;
    localparam int          DIV_CNT_W = 4;
    localparam logic [8:0]  Q_MAX     = 9'd450;

    localparam logic [11:0] TENTHS_RIGHT = 12'd900;
    localparam logic [11:0] TENTHS_HALF  = 12'd1800;
    localparam logic [11:0] TENTHS_FULL  = 12'd3600;

    localparam logic [8:0]  DEG_HALF = 9'd180;
    localparam logic [8:0]  DEG_FULL = 9'd360;

    // floor(t/10) = (t*6554) >> 16 for t <= 3600
    localparam logic [12:0] RECIP_TEN       = 13'd6554;
    // floor(v*256/180) = (v*93207) >> 16 for v <= 180
    localparam logic [16:0] RECIP_RAMP      = 17'd93207;
    localparam int          RECIP_SHIFT     = 16;
    localparam int          PROD_W          = 25;

    typedef struct packed {
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
    } chc_in_t;

    typedef struct packed {
        logic               calibrating;
        logic [15:0]        sample_index;
        logic [8:0]         heading_degrees;
        logic [8:0]         red_level;
        logic [8:0]         green_level;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
    } chc_out_t;

    typedef logic [15:0] chc_cfg_t;

    typedef struct packed {
        logic                 load;
        logic                 cal_update;
        logic                 cal_offset;
        logic                 hd_correct;
        logic                 hd_mag;
        logic                 div_step;
        logic [DIV_CNT_W-1:0] div_bit;
        logic                 hd_fold;
        logic                 hd_deg;
        logic                 lvl_red;
        logic                 lvl_green;
        logic                 out_load;
    } chc_cmd_t;

    typedef struct packed {
        logic calibrating;
    } chc_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/chc_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chc_stream_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface chc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/chc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chc_ctrl
// Sequencer: steps the datapath through calibration or heading for one item.
// ----------------------------------------------------------------------------
module chc_ctrl
    import chc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  chc_status_t status,
    output chc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL_UPD,
        ST_CAL_OFS,
        ST_HD_CORR,
        ST_HD_MAG,
        ST_HD_DIV,
        ST_HD_FOLD,
        ST_HD_DEG,
        ST_HD_RED,
        ST_HD_GREEN,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.calibrating ? ST_CAL_UPD : ST_HD_CORR;
                end
            end
            ST_CAL_UPD:
            begin
                cmd.cal_update = 1'b1;
                state_next     = ST_CAL_OFS;
            end
            ST_CAL_OFS:
            begin
                cmd.cal_offset = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_HD_CORR:
            begin
                cmd.hd_correct = 1'b1;
                state_next     = ST_HD_MAG;
            end
            ST_HD_MAG:
            begin
                cmd.hd_mag = 1'b1;
                cnt_next   = DIV_CNT_W'(DIV_BITS - 1);
                state_next = ST_HD_DIV;
            end
            ST_HD_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_bit  = cnt_reg;
                if (cnt_reg == '0)
                begin
                    state_next = ST_HD_FOLD;
                end
                else
                begin
                    cnt_next = cnt_reg - DIV_CNT_W'(1);
                end
            end
            ST_HD_FOLD:
            begin
                cmd.hd_fold = 1'b1;
                state_next  = ST_HD_DEG;
            end
            ST_HD_DEG:
            begin
                cmd.hd_deg = 1'b1;
                state_next = ST_HD_RED;
            end
            ST_HD_RED:
            begin
                cmd.lvl_red = 1'b1;
                state_next  = ST_HD_GREEN;
            end
            ST_HD_GREEN:
            begin
                cmd.lvl_green = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while an item is in progress");

    a_div_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HD_DIV |-> cnt_reg <= DIV_CNT_W'(DIV_BITS - 1))
        else $error("divider bit index out of range");

    a_fold_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HD_FOLD |-> $past(state_reg) == ST_HD_DIV && $past(cnt_reg) == '0)
        else $error("fold entered before the last divider step");

endmodule
`default_nettype wire

// ===== rtl/core/chc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chc_datapath
// Calibration min/max and offsets, offset removal, linear atan2 with a
// restoring divider, degree scaling and color ramps.
// ----------------------------------------------------------------------------
module chc_datapath
    import chc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  chc_cmd_t    cmd,
    output chc_status_t status,
    input  chc_in_t     in_data,
    input  logic        cfg_we,
    input  chc_cfg_t    cfg_data,
    output chc_out_t    out_data
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int CW = W + 1;
    localparam int NW = W + 10;

    localparam logic signed [W-1:0] S_TOP = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] S_BOT = {1'b1, {(W-1){1'b0}}};

    // control and calibration state
    logic [15:0]          cal_samples_reg;
    logic [15:0]          taken_reg;
    logic                 done_reg;
    logic signed [W-1:0]  min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [W-1:0]  off_x_reg, off_y_reg;

    // per-item working registers
    logic signed [W-1:0]  sx_reg, sy_reg;
    logic                 path_cal_reg;
    logic                 cal_last_reg;
    logic [15:0]          idx_reg;
    logic signed [W:0]    cx_reg, cy_reg;
    logic [W:0]           major_reg;
    logic [NW-1:0]        rem_reg;
    logic [DIV_BITS-1:0]  q_reg;
    logic                 steep_reg;
    logic [11:0]          tenths_reg;
    logic [8:0]           deg_reg;
    logic [8:0]           red_reg, green_reg;
    chc_out_t             out_reg;

    // calibration
    logic signed [W-1:0]  min_x_next, max_x_next, min_y_next, max_y_next;
    logic                 cal_last_next;
    logic signed [W:0]    sum_x, sum_y, adj_x, adj_y;

    assign min_x_next    = (sx_reg < min_x_reg) ? sx_reg : min_x_reg;
    assign max_x_next    = (sx_reg > max_x_reg) ? sx_reg : max_x_reg;
    assign min_y_next    = (sy_reg < min_y_reg) ? sy_reg : min_y_reg;
    assign max_y_next    = (sy_reg > max_y_reg) ? sy_reg : max_y_reg;
    assign cal_last_next = ({1'b0, taken_reg} + 17'd1) >= {1'b0, cal_samples_reg};

    // (min+max)/2 rounded toward zero: bump negatives before the shift
    assign sum_x = CW'(min_x_reg) + CW'(max_x_reg);
    assign sum_y = CW'(min_y_reg) + CW'(max_y_reg);
    assign adj_x = sum_x + CW'({1'b0, sum_x[W]});
    assign adj_y = sum_y + CW'({1'b0, sum_y[W]});

    // heading front end
    logic signed [W:0] cx_next, cy_next;
    logic [W:0]        ax, ay, minor;
    logic              steep_next, both_zero;
    logic [NW-1:0]     num_next, shifted;
    logic              div_ge;

    assign cx_next    = CW'(sx_reg) - CW'(off_x_reg);
    assign cy_next    = CW'(sy_reg) - CW'(off_y_reg);
    assign ax         = cx_reg[W] ? $unsigned(-cx_reg) : $unsigned(cx_reg);
    assign ay         = cy_reg[W] ? $unsigned(-cy_reg) : $unsigned(cy_reg);
    assign steep_next = ax < ay;
    assign minor      = steep_next ? ax : ay;
    assign num_next   = NW'(minor) * NW'(Q_MAX);
    assign both_zero  = (cx_reg == '0) && (cy_reg == '0);
    assign shifted    = NW'(major_reg) << cmd.div_bit;
    assign div_ge     = rem_reg >= shifted;

    // quadrant folding
    logic [11:0] a_base, tenths_next;

    assign a_base = steep_reg ? (TENTHS_RIGHT - 12'(q_reg)) : 12'(q_reg);

    always_comb
    begin
        case ({cx_reg[W], cy_reg[W]})
            2'b10:   tenths_next = TENTHS_HALF - a_base;
            2'b11:   tenths_next = TENTHS_HALF + a_base;
            2'b01:   tenths_next = TENTHS_FULL - a_base;
            default: tenths_next = a_base;
        endcase
        if (both_zero)
        begin
            tenths_next = '0;
        end
    end

    // degrees and color ramps; the two ramps share one multiplier
    logic [PROD_W-1:0] prod_deg, prod_lvl;
    logic [7:0]        ramp_red, ramp_green, ramp_sel;
    logic              low_half;

    assign prod_deg   = PROD_W'(tenths_reg) * PROD_W'(RECIP_TEN);
    assign low_half   = deg_reg <= DEG_HALF;
    assign ramp_red   = low_half ? deg_reg[7:0] : 8'(DEG_FULL - deg_reg);
    assign ramp_green = low_half ? 8'(DEG_HALF - deg_reg) : 8'(deg_reg - DEG_HALF);
    assign ramp_sel   = cmd.lvl_green ? ramp_green : ramp_red;
    assign prod_lvl   = PROD_W'(ramp_sel) * PROD_W'(RECIP_RAMP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_samples_reg <= CAL_SAMPLES_RESET;
            taken_reg       <= '0;
            done_reg        <= 1'b0;
            min_x_reg       <= S_TOP;
            min_y_reg       <= S_TOP;
            max_x_reg       <= S_BOT;
            max_y_reg       <= S_BOT;
            off_x_reg       <= '0;
            off_y_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cal_samples_reg <= cfg_data;
            end
            if (cmd.cal_update)
            begin
                min_x_reg <= min_x_next;
                max_x_reg <= max_x_next;
                min_y_reg <= min_y_next;
                max_y_reg <= max_y_next;
                taken_reg <= taken_reg + 16'd1;
            end
            if (cmd.cal_offset && cal_last_reg)
            begin
                off_x_reg <= adj_x[W:1];
                off_y_reg <= adj_y[W:1];
                done_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sx_reg       <= W'($unsigned(in_data.sample_x));
            sy_reg       <= W'($unsigned(in_data.sample_y));
            path_cal_reg <= !done_reg;
        end
        if (cmd.cal_update)
        begin
            idx_reg      <= taken_reg;
            cal_last_reg <= cal_last_next;
        end
        if (cmd.hd_correct)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
        if (cmd.hd_mag)
        begin
            major_reg <= steep_next ? ay : ax;
            rem_reg   <= num_next;
            steep_reg <= steep_next;
            q_reg     <= '0;
        end
        if (cmd.div_step && div_ge)
        begin
            rem_reg             <= rem_reg - shifted;
            q_reg[cmd.div_bit]  <= 1'b1;
        end
        if (cmd.hd_fold)
        begin
            tenths_reg <= tenths_next;
        end
        if (cmd.hd_deg)
        begin
            deg_reg <= prod_deg[RECIP_SHIFT +: 9];
        end
        if (cmd.lvl_red)
        begin
            red_reg <= prod_lvl[RECIP_SHIFT +: 9];
        end
        if (cmd.lvl_green)
        begin
            green_reg <= prod_lvl[RECIP_SHIFT +: 9];
        end
        if (cmd.out_load)
        begin
            out_reg.calibrating     <= path_cal_reg;
            out_reg.sample_index    <= path_cal_reg ? idx_reg : 16'd0;
            out_reg.heading_degrees <= path_cal_reg ? 9'd0 : deg_reg;
            out_reg.red_level       <= path_cal_reg ? 9'd0 : red_reg;
            out_reg.green_level     <= path_cal_reg ? 9'd0 : green_reg;
            out_reg.offset_x        <= FIELD_WIDTH'(off_x_reg);
            out_reg.offset_y        <= FIELD_WIDTH'(off_y_reg);
        end
    end

    assign status.calibrating = !done_reg;
    assign out_data           = out_reg;

    a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hd_fold && !both_zero |-> q_reg <= Q_MAX)
        else $error("atan ratio above 450");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("calibration restarted without reset");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && !path_cal_reg |-> deg_reg <= DEG_FULL && red_reg <= 9'd256)
        else $error("heading or level out of range");

endmodule
`default_nettype wire

// ===== rtl/core/compass_heading_with_calibration_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compass_heading_with_calibration_core
// Hard-iron calibrated magnetometer heading with red/green level ramps.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A calibration item steps through accept,
// min/max update, offset and output load. A heading item steps through
// accept, offset removal, magnitude, the restoring divider for
// 450*minor/major (one quotient bit per cycle), fold, degrees, red level,
// green level and output load. The next item is taken as soon as the result
// is in the output register, while that result may still wait downstream;
// if it still waits when the next result is ready, the core holds in its
// output load step until the result is taken.
// The calibration count register is written through cfg (always ready) and
// should only be changed while the core is idle.
// ----------------------------------------------------------------------------
module compass_heading_with_calibration_core
    import chc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    chc_stream_if.sink    sample,
    chc_stream_if.source  result,
    chc_stream_if.sink    cfg
);

    chc_cmd_t    cmd;
    chc_status_t status;

    assign cfg.ready = 1'b1;

    chc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    chc_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (sample.data),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.data),
        .out_data (result.data)
    );

endmodule
`default_nettype wire

// ===== test/tb_compass_heading_with_calibration_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compass_heading_with_calibration_core
// Self-checking bench for the calibrated compass heading core. It runs one
// calibration pass with the sample count changed midway, then directed and
// random heading items. Every accepted item is fed to a heading predictor,
// and each result is checked field by field in order. The sample and result
// channels idle at random except in the no-idle phases.
// ----------------------------------------------------------------------------
module tb_compass_heading_with_calibration_core;
    import chc_pkg::*;

    // Predicts the result of each sample and checks the core's results.
    class heading_scoreboard;
        chc_out_t    expected_results[$];
        int unsigned mismatches;
        bit [15:0]   cal_count;
        int          min_x, max_x, min_y, max_y;
        int          off_x, off_y;
        int unsigned samples_taken;
        bit          cal_done;

        function new();
            cal_count     = CAL_SAMPLES_RESET;
            min_x         = 32767;
            min_y         = 32767;
            max_x         = -32768;
            max_y         = -32768;
            off_x         = 0;
            off_y         = 0;
            samples_taken = 0;
            cal_done      = 1'b0;
            mismatches    = 0;
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        function void write_cal_count(chc_cfg_t value);
            cal_count = value;
        endfunction

        // Piecewise-linear atan2 in tenths of a degree.
        function int unsigned tenths_of_heading(int cy, int cx);
            int ay;
            int ax;
            int a;
            if (cx == 0 && cy == 0)
                return 0;
            ay = (cy < 0) ? -cy : cy;
            ax = (cx < 0) ? -cx : cx;
            if (ax >= ay)
                a = (450 * ay) / ax;
            else
                a = 900 - (450 * ax) / ay;
            if (cx < 0 && cy >= 0)
                a = 1800 - a;
            else if (cx < 0 && cy < 0)
                a = 1800 + a;
            else if (cx >= 0 && cy < 0)
                a = 3600 - a;
            return a;
        endfunction

        function void note_sample(chc_in_t s);
            chc_out_t    r;
            int          sx;
            int          sy;
            int unsigned idx;
            int unsigned hd;
            int unsigned red;
            int unsigned green;
            sx = int'(s.sample_x);
            sy = int'(s.sample_y);
            r  = '0;
            if (!cal_done) begin
                idx            = samples_taken;
                r.calibrating  = 1'b1;
                r.sample_index = idx[15:0];
                if (sx < min_x) min_x = sx;
                if (sx > max_x) max_x = sx;
                if (sy < min_y) min_y = sy;
                if (sy > max_y) max_y = sy;
                samples_taken = (samples_taken + 1) & 32'hFFFF;
                // a count of zero ends calibration on the first sample
                if (idx + 1 >= cal_count) begin
                    off_x    = (min_x + max_x) / 2;
                    off_y    = (min_y + max_y) / 2;
                    cal_done = 1'b1;
                end
            end
            else begin
                hd = tenths_of_heading(sy - off_y, sx - off_x) / 10;
                if (hd <= 180) begin
                    red   = (hd * 256) / 180;
                    green = ((180 - hd) * 256) / 180;
                end
                else begin
                    red   = ((360 - hd) * 256) / 180;
                    green = ((hd - 180) * 256) / 180;
                end
                r.heading_degrees = hd[8:0];
                r.red_level       = red[8:0];
                r.green_level     = green[8:0];
            end
            r.offset_x = off_x[15:0];
            r.offset_y = off_y[15:0];
            expected_results.push_back(r);
        endfunction

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(chc_out_t got);
            chc_out_t want;
            if (expected_results.size() == 0) begin
                flag_mismatch("result with no item outstanding");
                return;
            end
            want = expected_results.pop_front();
            compare_field("calibrating", 16'(got.calibrating), 16'(want.calibrating));
            compare_field("sample_index", got.sample_index, want.sample_index);
            compare_field("heading_degrees", 16'(got.heading_degrees),
                          16'(want.heading_degrees));
            compare_field("red_level", 16'(got.red_level), 16'(want.red_level));
            compare_field("green_level", 16'(got.green_level), 16'(want.green_level));
            compare_field("offset_x", got.offset_x, want.offset_x);
            compare_field("offset_y", got.offset_y, want.offset_y);
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;

    chc_stream_if #(.T(chc_in_t))  sample_ch ();
    chc_stream_if #(.T(chc_out_t)) result_ch ();
    chc_stream_if #(.T(chc_cfg_t)) cfg_ch ();

    heading_scoreboard sb = new();

    compass_heading_with_calibration_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Monitors: every handshake is seen at the rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (sample_ch.valid && sample_ch.ready)
                sb.note_sample(sample_ch.data);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.data);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_cal_count(cfg_ch.data);
        end
    end

    function automatic int unsigned pick_gap();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    // Result side: a random stall before taking each item.
    initial begin
        int unsigned stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    // Called at a falling edge; valid stays high after the item is taken.
    task automatic send_sample(logic [15:0] x, logic [15:0] y);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid         = 1'b1;
        sample_ch.data.sample_x = x;
        sample_ch.data.sample_y = y;
        do @(posedge clk); while (!sample_ch.ready);
        @(negedge clk);
    endtask

    // Sample placed relative to the current calibration offsets.
    task automatic send_rel(int dx, int dy);
        int x;
        int y;
        x = sb.off_x + dx;
        y = sb.off_y + dy;
        send_sample(x[15:0], y[15:0]);
    endtask

    task automatic send_cal_sample();
        int x;
        int y;
        x = int'($urandom_range(0, 10000)) - 4000;
        y = int'($urandom_range(0, 9000)) - 6000;
        send_sample(x[15:0], y[15:0]);
    endtask

    task automatic wait_drain();
        sample_ch.valid = 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_cal_count(chc_cfg_t value);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic random_heading_item();
        int unsigned kind;
        int          d;
        int          sx;
        int          sy;
        kind = $urandom_range(0, 19);
        d    = $urandom_range(1, 2000);
        sx   = $urandom_range(0, 1) ? d : -d;
        sy   = $urandom_range(0, 1) ? d : -d;
        if (kind < 11)
            send_sample(16'($urandom), 16'($urandom));
        else if (kind < 16)
            send_rel(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300);
        else begin
            // axes, diagonals and near-axis points
            case ($urandom_range(0, 3))
                0: send_rel(sx, 0);
                1: send_rel(0, sy);
                2: send_rel(sx, sy);
                default: send_rel(sx, $urandom_range(0, 1) ? 1 : -1);
            endcase
        end
    endtask

    initial begin
        chc_cfg_t post_cal_counts[4];
        post_cal_counts = '{16'd0, 16'hFFFF, 16'd1, 16'd200};

        rst_n            = 1'b0;
        no_idle          = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.data   = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Calibration, with the count moved while it runs.
        write_cal_count(16'hFFFF);
        repeat (5) send_cal_sample();
        wait_drain();
        write_cal_count(16'd12);
        repeat (3) send_cal_sample();
        wait_drain();
        // either passes the count at once or reaches it exactly
        write_cal_count($urandom_range(0, 1) ? 16'd0 : 16'd10);
        while (!sb.cal_done)
            send_cal_sample();
        wait_drain();

        // Directed heading items.
        send_rel(0, 0);
        send_rel(100, 0);
        send_rel(0, 100);
        send_rel(-100, 0);
        send_rel(0, -100);
        send_rel(100, 100);
        send_rel(-100, 100);
        send_rel(-100, -100);
        send_rel(100, -100);
        send_rel(1000, -1);   // just below east, folds to 360
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        wait_drain();

        // Random phases; count writes after calibration must change nothing.
        for (int phase = 0; phase < 8; phase++) begin
            write_cal_count(phase % 4 == 3 ? chc_cfg_t'($urandom) : post_cal_counts[phase % 4]);
            no_idle = (phase % 3 == 1);
            repeat (116) random_heading_item();
            wait_drain();
        end
        no_idle = 1'b0;

        repeat (40) @(negedge clk);
        if (sb.expected_results.size() != 0)
            sb.flag_mismatch("expected results left over at end of run");
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
